[hw/rtl/teq_pkg.sv]
// Package for the time-ordered event queue.
// Holds the queue depth, status codes, the entry type and the cell control struct.
// No dependencies.
package teq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_POPPED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [31:0] time_key;
    logic [15:0] dest_node;
    logic [15:0] origin_node;
    logic [15:0] msg_target;
    logic [15:0] msg_cost_l;
    logic [19:0] msg_cost_w;
  } teq_entry_t;

  typedef struct packed {
    logic       insert;
    logic       pop;
    teq_entry_t new_entry;
  } teq_ctrl_t;

endpackage

[hw/rtl/teq_cell.sv]
// One storage cell of the sorted event queue.
// Depends on teq_pkg for the entry and control types.
module teq_cell
  import teq_pkg::*;
(
  input  logic       clk,
  input  teq_ctrl_t  ctrl,
  input  logic       valid,
  input  teq_entry_t left_entry,
  input  logic       left_le,
  input  teq_entry_t right_entry,
  output teq_entry_t entry,
  output logic       le
);

  teq_entry_t entry_next;

  // A cell is at or below the new key when it holds an event no later than it.
  assign le = valid && (entry.time_key <= ctrl.new_entry.time_key);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert && !le) begin
      if (left_le) begin
        entry_next = ctrl.new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[hw/rtl/time_ordered_event_queue.sv]
// Time-ordered event queue: top level with the cell chain, fill count and output register.
// Depends on teq_pkg and teq_cell.
//
// The block keeps up to QUEUE_DEPTH events sorted by time in a row of cells; every
// cell compares its own time against the incoming key in the same cycle and either
// holds, takes the new event, takes its left neighbor or, on a pop, its right one,
// so all cells update together on an insert or a pop; one transaction is accepted
// every cycle while the output register can be emptied. Results are registered on
// acceptance and show in the next cycle. Events with equal times leave in arrival order.
// An insert into a full queue is dropped with status full; a pop on an empty queue returns
// status empty. Payload fields of the result are zero unless the status is popped.
module time_ordered_event_queue
  import teq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // event_time[31:0], dest_node[47:32], origin_node[63:48], msg_target[79:64],
  // msg_cost_l[95:80], msg_cost_w[115:96], zero fill up to bit 119.
  input  logic [119:0] s_tdata,
  // opcode[0].
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_time[31:0], out_dest_node[47:32], out_origin_node[63:48],
  // out_msg_target[79:64], out_cost_l[95:80], out_cost_w[115:96],
  // occupancy[122:116], zero fill up to bit 127.
  output logic [127:0] m_tdata,
  // status[1:0].
  output logic [1:0]   m_tuser
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  teq_ctrl_t        ctrl;
  teq_entry_t       cell_entry [QUEUE_DEPTH];
  logic             cell_le    [QUEUE_DEPTH];
  logic [1:0]       status;
  teq_entry_t       result;
  logic [127:0]     tdata_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctrl.new_entry.time_key    = s_tdata[31:0];
  assign ctrl.new_entry.dest_node   = s_tdata[47:32];
  assign ctrl.new_entry.origin_node = s_tdata[63:48];
  assign ctrl.new_entry.msg_target  = s_tdata[79:64];
  assign ctrl.new_entry.msg_cost_l  = s_tdata[95:80];
  assign ctrl.new_entry.msg_cost_w  = s_tdata[115:96];
  assign ctrl.insert = accept && (s_tuser[0] == OP_INSERT) && !full;
  assign ctrl.pop    = accept && (s_tuser[0] == OP_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    teq_entry_t left_entry;
    teq_entry_t right_entry;
    logic       left_le;
    logic       valid;

    assign valid = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = ctrl.new_entry;
      assign left_le    = 1'b1;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_shift
      assign right_entry = cell_entry[i+1];
    end

    teq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (valid),
      .left_entry  (left_entry),
      .left_le     (left_le),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .le          (cell_le[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    result = '0;
    if (s_tuser[0] == OP_INSERT) begin
      status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      status = ST_EMPTY;
    end else begin
      status = ST_POPPED;
      result = cell_entry[0];
    end
  end

  always_comb begin
    tdata_next          = '0;
    tdata_next[31:0]    = result.time_key;
    tdata_next[47:32]   = result.dest_node;
    tdata_next[63:48]   = result.origin_node;
    tdata_next[79:64]   = result.msg_target;
    tdata_next[95:80]   = result.msg_cost_l;
    tdata_next[115:96]  = result.msg_cost_w;
    tdata_next[122:116] = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= tdata_next;
      m_tuser <= status;
    end
  end

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser[0] == OP_INSERT) && full) |=> (m_tuser == ST_FULL && full))
    else $error("insert into a full queue was not rejected");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser[0] == OP_POP) && !empty) |=> (count == $past(count) - CNT_W'(1)))
    else $error("pop did not lower the fill count by one");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_entry[0].time_key <= cell_entry[1].time_key))
    else $error("head cells are out of time order");

endmodule
